// ----- sv/wsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser, the result queue and the
// top level.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Parse phase of the frame header and body.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXT_HI  = 3'd2,
        PH_EXT_LO  = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6,
        PH_UNSUP   = 3'd7
    } phase_t;

    // End-of-chunk status codes.
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_CLOSE = 3'd1,
        ST_SHORT = 3'd2,
        ST_UNSUP = 3'd3,
        ST_TRUNC = 3'd4
    } status_t;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Header constants.
    localparam logic [3:0] OPC_CLOSE   = 4'h8;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1023;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [15:0] frame_length;
        logic [3:0]  frame_opcode;
        logic        is_last;
    } result_t;

    // Results produced by one accepted byte (zero, one or two).
    typedef struct packed {
        logic [1:0] n;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

// ----- sv/wsd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Holds the header state and the mask key, and turns each accepted byte into
// at most one payload result followed by at most one status result.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
#(
    parameter int MAX_CHUNK = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic        chunk_end,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    output push_t       push
);

    localparam int CW = $clog2(MAX_CHUNK + 1);
    localparam int LW = (CW > 16) ? CW : 16;

    phase_t       phase_reg, phase_next;
    logic [3:0]   opcode_reg, opcode_next;
    logic         masked_reg, masked_next;
    logic [6:0]   len_code_reg, len_code_next;
    logic [15:0]  pay_len_reg, pay_len_next;
    logic [31:0]  key_reg, key_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [CW-1:0] pay_idx_reg, pay_idx_next;
    logic [1:0]   key_idx_reg, key_idx_next;
    logic [15:0]  max_payload_reg;

    logic         pay_valid;
    logic [7:0]   pay_data;
    logic [7:0]   key_byte;
    status_t      st;
    result_t      pay_res;
    result_t      stat_res;

    // Mask key byte selected by the payload index, most significant first.
    always_comb
    begin
        case (pay_idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // One parse step for the accepted byte.
    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        masked_next     = masked_reg;
        len_code_next   = len_code_reg;
        pay_len_next    = pay_len_reg;
        key_next        = key_reg;
        byte_count_next = byte_count_reg;
        pay_idx_next    = pay_idx_reg;
        key_idx_next    = key_idx_reg;
        pay_valid       = 1'b0;
        pay_data        = rx_byte;
        st              = ST_OK;

        if (accept && (byte_count_reg < CW'(MAX_CHUNK)))
        begin
            byte_count_next = byte_count_reg + CW'(1);
            case (phase_reg)
                PH_FIRST:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_SECOND;
                end
                PH_SECOND:
                begin
                    masked_next   = rx_byte[7];
                    len_code_next = rx_byte[6:0];
                    if (rx_byte[6:0] == LEN_CODE_16)
                    begin
                        phase_next = PH_EXT_HI;
                    end
                    else if (rx_byte[6:0] == LEN_CODE_64)
                    begin
                        phase_next = PH_UNSUP;
                    end
                    else
                    begin
                        pay_len_next = {9'd0, rx_byte[6:0]};
                        if (rx_byte[7])
                        begin
                            key_idx_next = 2'd0;
                            phase_next   = PH_MASK;
                        end
                        else
                        begin
                            pay_idx_next = '0;
                            phase_next   = (rx_byte[6:0] == 7'd0) ? PH_DONE : PH_PAYLOAD;
                        end
                    end
                end
                PH_EXT_HI:
                begin
                    pay_len_next = {rx_byte, 8'd0};
                    phase_next   = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    pay_len_next = {pay_len_reg[15:8], rx_byte};
                    if (masked_reg)
                    begin
                        key_idx_next = 2'd0;
                        phase_next   = PH_MASK;
                    end
                    else
                    begin
                        pay_idx_next = '0;
                        phase_next   = ({pay_len_reg[15:8], rx_byte} == 16'd0) ?
                                       PH_DONE : PH_PAYLOAD;
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (key_idx_reg == 2'd3)
                    begin
                        pay_idx_next = '0;
                        phase_next   = (pay_len_reg == 16'd0) ? PH_DONE : PH_PAYLOAD;
                    end
                    else
                    begin
                        key_idx_next = key_idx_reg + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if ((opcode_reg != OPC_CLOSE) &&
                        (LW'(pay_idx_reg) < LW'(max_payload_reg)))
                    begin
                        pay_valid = 1'b1;
                        if (masked_reg)
                        begin
                            pay_data = rx_byte ^ key_byte;
                        end
                    end
                    pay_idx_next = pay_idx_reg + CW'(1);
                    if (LW'(pay_idx_next) >= LW'(pay_len_reg))
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Status from the phase reached after this byte.
        case (phase_next)
            PH_FIRST, PH_SECOND, PH_EXT_HI, PH_EXT_LO: st = ST_SHORT;
            PH_MASK, PH_PAYLOAD:                       st = ST_TRUNC;
            PH_UNSUP:                                  st = ST_UNSUP;
            default: st = (opcode_next == OPC_CLOSE) ? ST_CLOSE : ST_OK;
        endcase

        pay_res.kind         = KIND_PAYLOAD;
        pay_res.data_byte    = pay_data;
        pay_res.status       = ST_OK;
        pay_res.frame_length = pay_len_reg;
        pay_res.frame_opcode = opcode_reg;
        pay_res.is_last      = 1'b0;

        stat_res.kind         = KIND_STATUS;
        stat_res.data_byte    = 8'd0;
        stat_res.status       = st;
        stat_res.frame_length = pay_len_next;
        stat_res.frame_opcode = opcode_next;
        stat_res.is_last      = 1'b1;

        // The chunk end returns all parse state to its reset value.
        if (accept && chunk_end)
        begin
            phase_next      = PH_FIRST;
            opcode_next     = 4'd0;
            masked_next     = 1'b0;
            len_code_next   = 7'd0;
            pay_len_next    = 16'd0;
            key_next        = 32'd0;
            byte_count_next = '0;
            pay_idx_next    = '0;
            key_idx_next    = 2'd0;
        end

        push.n    = {1'b0, pay_valid} + {1'b0, accept && chunk_end};
        push.res0 = pay_valid ? pay_res : stat_res;
        push.res1 = stat_res;
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            opcode_reg     <= 4'd0;
            masked_reg     <= 1'b0;
            len_code_reg   <= 7'd0;
            pay_len_reg    <= 16'd0;
            key_reg        <= 32'd0;
            byte_count_reg <= '0;
            pay_idx_reg    <= '0;
            key_idx_reg    <= 2'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            opcode_reg     <= opcode_next;
            masked_reg     <= masked_next;
            len_code_reg   <= len_code_next;
            pay_len_reg    <= pay_len_next;
            key_reg        <= key_next;
            byte_count_reg <= byte_count_next;
            pay_idx_reg    <= pay_idx_next;
            key_idx_reg    <= key_idx_next;
        end
    end

    // Payload cap register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid)
        begin
            max_payload_reg <= cfg_data;
        end
    end

endmodule

// ----- sv/wsd_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer result queue
// Four-entry queue that takes up to two results per cycle from the parser and
// hands one result per cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module wsd_out_queue
    import wsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_ok,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    result_t        entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           pop;

    // Room for two results lets any byte be taken.
    assign space_ok  = (count_reg <= (QAW + 1)'(QDEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push.n);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + (QAW + 1)'(push.n) - (QAW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + QAW'(1)] <= push.res1;
        end
    end

endmodule

// ----- sv/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one frame header per received chunk, unmasks the payload bytes and
// reports a status after the last byte of each chunk.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       sink       in_valid / in_ready   rx_byte, chunk_end
//  out      source     out_valid / out_ready kind, data_byte, status,
//                                            frame_length, frame_opcode, is_last
//  cfg      sink       cfg_valid / cfg_ready cfg_data (max_payload)
//
// A byte is parsed in the cycle it is accepted; its results enter a four-entry
// queue and the first can be taken in the next cycle. One byte per cycle is
// sustained while the output keeps taking results; a chunk-end byte with a
// payload result gives two results. in_ready is low while the queue holds more
// than two results. Reset clears the parse state and the queue and sets
// max_payload to 1023. cfg_ready is always high.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int MAX_CHUNK = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        chunk_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [2:0]  status,
    output logic [15:0] frame_length,
    output logic [3:0]  frame_opcode,
    output logic        is_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    push_t   push;
    result_t head;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // Header parser and unmasking.
    wsd_parser #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .chunk_end (chunk_end),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    // Result queue towards the output channel.
    wsd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind         = head.kind;
    assign data_byte    = head.data_byte;
    assign status       = head.status;
    assign frame_length = head.frame_length;
    assign frame_opcode = head.frame_opcode;
    assign is_last      = head.is_last;

    // Results are only produced by an accepted byte.
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> (push.n == 2'd0))
        else $error("results produced without an accepted byte");

    // A pair of results is always a payload byte followed by the status.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (push.res0.kind == KIND_PAYLOAD &&
                              push.res1.kind == KIND_STATUS && chunk_end))
        else $error("result pair out of order");

    // A status result is pushed exactly when a chunk-end byte is accepted.
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chunk_end) |-> (push.n != 2'd0 &&
            (push.n == 2'd2 ? push.res1.is_last : push.res0.is_last)))
        else $error("chunk end without status result");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_STATUS) |-> (status <= ST_TRUNC))
        else $error("undefined status code");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the WebSocket frame deframer
// Sends chunks of received bytes through the input channel and checks every
// unmasked payload byte and end-of-chunk status against a behavioural model
// of the parser. A short table of hand-written frames comes first. Random
// frames follow, under several payload caps, with bursty input, a stalling
// output and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import wsd_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int CHUNK_BOUND  = 1024;
    localparam int N_DIRECTED   = 26;
    localparam int PHASE_BYTES  = 50;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int TIMEOUT_NS   = 5000000;

    // One input request, with an optional hand-typed end-of-chunk status.
    typedef struct packed {
        logic [7:0]  rx;
        logic        last;
        logic        pinned;
        status_t     pin_status;
        logic [15:0] pin_length;
        logic [3:0]  pin_opcode;
    } rx_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        chunk_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] frame_length;
    logic [3:0]  frame_opcode;
    logic        is_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    rx_req_t rx_requests[$];
    result_t pending_results[$];
    rx_req_t directed_rows [N_DIRECTED];
    int      mismatch_count = 0;

    // Model of the parser state and of the payload cap.
    phase_t      p_phase;
    logic [3:0]  p_opcode;
    logic        p_masked;
    logic [15:0] p_len;
    logic [31:0] p_key;
    int          p_key_idx;
    int          p_count;
    int          p_pay_idx;
    int          cap_bytes = int'(MAX_PAYLOAD_RESET);

    // Sender and receiver pacing.
    int burst_left = 0;
    int gap_left = 0;
    int ready_window = 0;
    int ready_mode = 0;
    int ready_tick = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit hold_request = 1'b0;

    websocket_frame_deframer #(
        .MAX_CHUNK(CHUNK_BOUND)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .chunk_end(chunk_end),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .data_byte(data_byte),
        .status(status),
        .frame_length(frame_length),
        .frame_opcode(frame_opcode),
        .is_last(is_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 0;
    end

    // Return the parser model to its state at the start of a chunk.
    function automatic void clear_parse();
        p_phase   = PH_FIRST;
        p_opcode  = 4'h0;
        p_masked  = 1'b0;
        p_len     = 16'h0000;
        p_key     = 32'h0;
        p_key_idx = 0;
        p_count   = 0;
        p_pay_idx = 0;
    endfunction

    // After the length field: key bytes next if masked, else the body.
    function automatic void enter_body();
        if (p_masked)
        begin
            p_key_idx = 0;
            p_phase   = PH_MASK;
        end
        else
        begin
            p_pay_idx = 0;
            p_phase   = (p_len == 16'h0000) ? PH_DONE : PH_PAYLOAD;
        end
    endfunction

    // Work out the results that one accepted byte causes.
    function automatic void deframe_byte(input rx_req_t req);
        result_t     res;
        status_t     st;
        logic [31:0] key_part;
        logic [7:0]  b;
        b = req.rx;
        if (p_count < CHUNK_BOUND)
        begin
            p_count++;
            case (p_phase)
                PH_FIRST:
                begin
                    p_opcode = b[3:0];
                    p_phase  = PH_SECOND;
                end
                PH_SECOND:
                begin
                    p_masked = b[7];
                    if (b[6:0] == LEN_CODE_16)
                        p_phase = PH_EXT_HI;
                    else if (b[6:0] == LEN_CODE_64)
                        p_phase = PH_UNSUP;
                    else
                    begin
                        p_len = {9'd0, b[6:0]};
                        enter_body();
                    end
                end
                PH_EXT_HI:
                begin
                    p_len   = {b, 8'h00};
                    p_phase = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    p_len = {p_len[15:8], b};
                    enter_body();
                end
                PH_MASK:
                begin
                    p_key = {p_key[23:0], b};
                    if (p_key_idx >= 3)
                    begin
                        p_pay_idx = 0;
                        p_phase   = (p_len == 16'h0000) ? PH_DONE : PH_PAYLOAD;
                    end
                    else
                        p_key_idx++;
                end
                PH_PAYLOAD:
                begin
                    // Close frames swallow their body; others emit up to the cap.
                    if (p_opcode != OPC_CLOSE && p_pay_idx < cap_bytes)
                    begin
                        key_part = p_masked ? (p_key >> (24 - 8 * (p_pay_idx % 4))) : 32'h0;
                        res.kind         = KIND_PAYLOAD;
                        res.data_byte    = b ^ key_part[7:0];
                        res.status       = ST_OK;
                        res.frame_length = p_len;
                        res.frame_opcode = p_opcode;
                        res.is_last      = 1'b0;
                        pending_results.push_back(res);
                    end
                    p_pay_idx++;
                    if (p_pay_idx >= int'(p_len))
                        p_phase = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end

        // The chunk-end mark always gives a status, even past the chunk bound.
        if (req.last)
        begin
            case (p_phase)
                PH_FIRST, PH_SECOND, PH_EXT_HI, PH_EXT_LO: st = ST_SHORT;
                PH_MASK, PH_PAYLOAD: st = ST_TRUNC;
                PH_UNSUP: st = ST_UNSUP;
                default: st = (p_opcode == OPC_CLOSE) ? ST_CLOSE : ST_OK;
            endcase
            res.kind         = KIND_STATUS;
            res.data_byte    = 8'h00;
            res.status       = st;
            res.frame_length = p_len;
            res.frame_opcode = p_opcode;
            res.is_last      = 1'b1;
            if (req.pinned)
            begin
                res.status       = req.pin_status;
                res.frame_length = req.pin_length;
                res.frame_opcode = req.pin_opcode;
            end
            pending_results.push_back(res);
            clear_parse();
        end
    endfunction

    // Queue the first cut bytes of a frame as one chunk.
    function automatic void queue_chunk(input logic [7:0] frame[$], input int cut);
        rx_req_t req;
        for (int i = 0; i < cut; i++)
        begin
            req = '{frame[i], (i == cut - 1), 1'b0, ST_OK, 16'h0000, 4'h0};
            rx_requests.push_back(req);
        end
    endfunction

    // One random chunk: mostly well-formed frames, some broken ones and noise.
    function automatic int queue_random_chunk();
        logic [7:0] frame[$];
        logic [3:0] opc;
        logic       masked;
        int         sel;
        int         body_len;
        int         cut;
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
            cut = frame.size();
        end
        else
        begin
            opc      = ($urandom_range(0, 5) == 0) ? OPC_CLOSE : 4'($urandom_range(0, 15));
            masked   = 1'($urandom_range(0, 1));
            body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                                   : $urandom_range(0, 20);
            frame.push_back({4'($urandom_range(0, 15)), opc});
            if (body_len > 125 || $urandom_range(0, 7) == 0)
            begin
                frame.push_back({masked, LEN_CODE_16});
                frame.push_back(8'(body_len >> 8));
                frame.push_back(8'(body_len));
            end
            else
                frame.push_back({masked, 7'(body_len)});
            if (sel < 17)
                frame[1] = {masked, LEN_CODE_64};
            if (masked)
                repeat (4) frame.push_back(8'($urandom_range(0, 255)));
            repeat (body_len) frame.push_back(8'($urandom_range(0, 255)));
            if (sel >= 32 && sel < 42)
                repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
            cut = frame.size();
            if (sel >= 17 && sel < 32)
                cut = $urandom_range(1, frame.size());
        end
        queue_chunk(frame, cut);
        return cut;
    endfunction

    // A chunk longer than the chunk bound, with a 16-bit declared length.
    function automatic int queue_long_chunk(input int declared, input int total,
                                            input logic masked);
        logic [7:0] frame[$];
        frame.push_back(8'h82);
        frame.push_back({masked, LEN_CODE_16});
        frame.push_back(8'(declared >> 8));
        frame.push_back(8'(declared));
        if (masked)
            repeat (4) frame.push_back(8'($urandom_range(0, 255)));
        while (frame.size() < total)
            frame.push_back(8'($urandom_range(0, 255)));
        queue_chunk(frame, total);
        return total;
    endfunction

    // Fill one phase worth of random requests.
    task automatic queue_phase();
        int queued;
        queued = 0;
        @(negedge clk);
        while (queued < PHASE_BYTES)
            queued += queue_random_chunk();
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((rx_requests.size() != 0 || in_valid || pending_results.size() != 0)
               && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    // Write the payload cap while the block is idle.
    task automatic write_payload_cap(input logic [15:0] value);
        wait_drained();
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cap_bytes = int'(cfg_data);
        cfg_valid <= 1'b0;
    endtask

    // Sender: presents the oldest request, in bursts with gaps between them.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            deframe_byte(rx_requests.pop_front());
        if (!(in_valid && !in_ready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (rx_requests.size() > 0)
            begin
                in_valid  <= 1'b1;
                rx_byte   <= rx_requests[0].rx;
                chunk_end <= rx_requests[0].last;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 64);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: a stall pattern that changes every window, plus one long hold.
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (ready_window == 0)
            begin
                ready_mode   = $urandom_range(0, 3);
                ready_window = $urandom_range(16, 96);
            end
            ready_window--;
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ((ready_tick % 5) < 3);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
        ready_tick++;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {kind, data_byte, status, frame_length, frame_opcode, is_last};
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: unexpected result ", $realtime,
                             "kind=%0d data=%h status=%0d len=%0d opc=%h last=%0d",
                             got.kind, got.data_byte, got.status,
                             got.frame_length, got.frame_opcode, got.is_last);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte
                    || got.status !== want.status || got.frame_length !== want.frame_length
                    || got.frame_opcode !== want.frame_opcode || got.is_last !== want.is_last)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: expected ", $realtime,
                                 "kind=%0d data=%h status=%0d len=%0d opc=%h last=%0d",
                                 want.kind, want.data_byte, want.status,
                                 want.frame_length, want.frame_opcode, want.is_last,
                                 ", got kind=%0d data=%h status=%0d len=%0d opc=%h last=%0d",
                                 got.kind, got.data_byte, got.status,
                                 got.frame_length, got.frame_opcode, got.is_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset, hand-written frames, then random phases.
    initial
    begin
        logic [15:0] cap_plan [5];
        cap_plan = '{16'd0, 16'hFFFF, 16'd3, 16'($urandom_range(0, 40)), MAX_PAYLOAD_RESET};
        clear_parse();

        // Hand-written frames; the status is typed in where it is obvious.
        directed_rows = '{
            // Chunk of a single header byte.
            '{8'h81, 1'b1, 1'b1, ST_SHORT, 16'h0000, 4'h1},
            // Chunk ends inside the extended length.
            '{8'h82, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'hFE, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h12, 1'b1, 1'b1, ST_SHORT, 16'h1200, 4'h2},
            // 64-bit length code; the rest of the chunk is ignored.
            '{8'h8F, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h7F, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'hAA, 1'b1, 1'b1, ST_UNSUP, 16'h0000, 4'hF},
            // Zero header byte, unmasked one-byte payload of zero.
            '{8'h00, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h01, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h00, 1'b1, 1'b0, ST_OK,    16'h0000, 4'h0},
            // Masked one-byte payload with an all-ones key.
            '{8'h82, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h81, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'hFF, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'hFF, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'hFF, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'hFF, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h00, 1'b1, 1'b0, ST_OK,    16'h0000, 4'h0},
            // Close frame with a body that is not emitted.
            '{8'h88, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h01, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h55, 1'b1, 1'b1, ST_CLOSE, 16'h0001, 4'h8},
            // Chunk ends inside the mask key.
            '{8'h8A, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h80, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h11, 1'b1, 1'b1, ST_TRUNC, 16'h0000, 4'hA},
            // Empty frame followed by a byte that is ignored.
            '{8'h09, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h00, 1'b0, 1'b0, ST_OK,    16'h0000, 4'h0},
            '{8'h33, 1'b1, 1'b1, ST_OK,    16'h0000, 4'h9}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        foreach (directed_rows[i])
            rx_requests.push_back(directed_rows[i]);
        wait_drained();

        // First random phase at the reset cap, with a long output hold-off.
        queue_phase();
        hold_request = 1'b1;

        // Further phases, one under each cap of the plan; each starts from an idle block.
        foreach (cap_plan[i])
        begin
            write_payload_cap(cap_plan[i]);
            if (cap_plan[i] == 16'hFFFF)
            begin
                @(negedge clk);
                void'(queue_long_chunk(1100, 1030, 1'b1));
            end
            queue_phase();
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0 && rx_requests.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #TIMEOUT_NS;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- websocket_frame_deframer.f -----
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/wsd_out_queue.sv
sv/websocket_frame_deframer.sv
bench/tb_top.sv
